[hw/rtl/cbsu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cbsu_pkg;

  // opcode class, func bits 7..6
  localparam logic [1:0] CLS_SHIFT = 2'd0;
  localparam logic [1:0] CLS_BIT   = 2'd1;
  localparam logic [1:0] CLS_RES   = 2'd2;
  localparam logic [1:0] CLS_SET   = 2'd3;

  // shift kind, func bits 5..3 when class is shift
  localparam logic [2:0] SH_RLC  = 3'd0;
  localparam logic [2:0] SH_RRC  = 3'd1;
  localparam logic [2:0] SH_RL   = 3'd2;
  localparam logic [2:0] SH_RR   = 3'd3;
  localparam logic [2:0] SH_SLA  = 3'd4;
  localparam logic [2:0] SH_SRA  = 3'd5;
  localparam logic [2:0] SH_SWAP = 3'd6;
  localparam logic [2:0] SH_SRL  = 3'd7;

  // target code for the byte at HL
  localparam logic [2:0] TARGET_MEM = 3'd6;

  // flag bit positions
  localparam int FLAG_Z = 3;
  localparam int FLAG_N = 2;
  localparam int FLAG_H = 1;
  localparam int FLAG_C = 0;

  // machine cycle counts
  localparam logic [4:0] CYC_REG     = 5'd8;
  localparam logic [4:0] CYC_MEM_BIT = 5'd12;
  localparam logic [4:0] CYC_MEM     = 5'd16;

  typedef struct packed {
    logic [7:0] func;
    logic [7:0] operand;
    logic [3:0] flags_in;
  } cbsu_req_t;

  typedef struct packed {
    logic [7:0] result;
    logic [3:0] flags_out;
    logic       write_result;
    logic [2:0] target_index;
    logic       uses_memory;
    logic [4:0] cycle_count;
  } cbsu_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/cbsu_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbsu_exec
  import cbsu_pkg::*;
(
  input  cbsu_req_t req,
  output cbsu_rsp_t rsp
);

  logic [1:0] cls;
  logic [2:0] sel;
  logic [2:0] tgt;
  logic [7:0] v;
  logic [7:0] mask;
  logic [7:0] sh_res;
  logic       sh_cout;
  logic       mem;

  assign cls  = req.func[7:6];
  assign sel  = req.func[5:3];
  assign tgt  = req.func[2:0];
  assign v    = req.operand;
  assign mask = 8'b1 << sel;
  assign mem  = (tgt == TARGET_MEM);

  // rotate / shift / swap unit
  always_comb begin
    case (sel)
      SH_RLC: begin
        sh_cout = v[7];
        sh_res  = {v[6:0], v[7]};
      end
      SH_RRC: begin
        sh_cout = v[0];
        sh_res  = {v[0], v[7:1]};
      end
      SH_RL: begin
        sh_cout = v[7];
        sh_res  = {v[6:0], req.flags_in[FLAG_C]};
      end
      SH_RR: begin
        sh_cout = v[0];
        sh_res  = {req.flags_in[FLAG_C], v[7:1]};
      end
      SH_SLA: begin
        sh_cout = v[7];
        sh_res  = {v[6:0], 1'b0};
      end
      SH_SRA: begin
        sh_cout = v[0];
        sh_res  = {v[7], v[7:1]};
      end
      SH_SWAP: begin
        sh_cout = 1'b0;
        sh_res  = {v[3:0], v[7:4]};
      end
      default: begin
        sh_cout = v[0];
        sh_res  = {1'b0, v[7:1]};
      end
    endcase
  end

  always_comb begin
    rsp.result       = v;
    rsp.flags_out    = req.flags_in;
    rsp.write_result = 1'b1;
    rsp.target_index = tgt;
    rsp.uses_memory  = mem;
    case (cls)
      CLS_SHIFT: begin
        rsp.result    = sh_res;
        rsp.flags_out = {(sh_res == 8'd0), 1'b0, 1'b0, sh_cout};
      end
      CLS_BIT: begin
        rsp.write_result = 1'b0;
        rsp.flags_out    = {((v & mask) == 8'd0), 1'b0, 1'b1, req.flags_in[FLAG_C]};
      end
      CLS_RES: begin
        rsp.result = v & ~mask;
      end
      default: begin
        rsp.result = v | mask;
      end
    endcase
    if (!mem) begin
      rsp.cycle_count = CYC_REG;
    end else if (cls == CLS_BIT) begin
      rsp.cycle_count = CYC_MEM_BIT;
    end else begin
      rsp.cycle_count = CYC_MEM;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/cb_prefix_bit_shift_unit_top.sv]
// prefixed bit / shift unit: one opcode byte in, one result out per request
// path: an accepted request goes through the input stage reg, then the result reg
// throughput: one request per cycle while rsp_ready keeps the result register draining
// reset: synchronous active-high rst clears both valid flags, payload regs not reset
`timescale 1ns / 1ps
`default_nettype none

module cb_prefix_bit_shift_unit_top
  import cbsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  cbsu_req_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output cbsu_rsp_t rsp
);

  // input stage holding the accepted request
  logic      stage_valid;
  cbsu_req_t stage_req;

  // decoded / executed result of the staged request
  cbsu_rsp_t exec_rsp;

  // result register may load when empty or being drained this cycle
  logic      advance;

  assign advance   = !rsp_valid || rsp_ready;
  // input stage frees up when empty or when its request moves on
  assign req_ready = !stage_valid || advance;

  cbsu_exec u_exec (
    .req (stage_req),
    .rsp (exec_rsp)
  );

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (req_ready) begin
        stage_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= stage_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      stage_req <= req;
    end
    if (advance && stage_valid) begin
      rsp <= exec_rsp;
    end
  end

  // an accepted request always lands in the input stage
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> stage_valid)
    else $error("accepted request not captured");

  // a stalled response keeps the staged request waiting
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready && stage_valid) |=> (stage_valid && rsp_valid))
    else $error("staged request lost under stall");

  // bit test never writes back and always sets H
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.write_result) |-> rsp.flags_out[FLAG_H])
    else $error("bit test response without H");

  // memory flag tracks the target code
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.uses_memory == (rsp.target_index == TARGET_MEM)))
    else $error("uses_memory mismatch");

  // register targets take the short cycle count
  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.uses_memory) |-> (rsp.cycle_count == CYC_REG))
    else $error("wrong cycle count for register target");

endmodule

`default_nettype wire

[tb/sv/cb_prefix_bit_shift_unit_top_test.sv]
`timescale 1ns / 1ps

module cb_prefix_bit_shift_unit_top_test;
  import cbsu_pkg::*;

  // register target codes, func bits 2..0 (the byte at HL is TARGET_MEM)
  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_C = 3'd1;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;
  localparam logic [2:0] REG_H = 3'd4;
  localparam logic [2:0] REG_L = 3'd5;
  localparam logic [2:0] REG_A = 3'd7;

  // flag nibbles used by the directed requests
  localparam logic [3:0] FL_NONE = 4'h0;
  localparam logic [3:0] FL_ALL  = 4'hF;
  localparam logic [3:0] FL_C    = 4'h1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  cbsu_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  cbsu_rsp_t rsp;

  // predicted responses, oldest first
  cbsu_rsp_t predicted_rsp_q[$];

  // sender and checker bookkeeping
  int n_issued = 0;      // requests accepted, counted by the sender
  int n_retired = 0;     // responses accepted, counted by the checker
  int n_mismatch = 0;
  int n_errors = 0;

  // idle knobs shared by the test tasks, the sender task and the receiver process
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int rx_hold_cycles = 0;

  cb_prefix_bit_shift_unit_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // what the unit should return for one prefixed opcode
  function automatic cbsu_rsp_t cb_execute(cbsu_req_t r);
    logic [1:0] cls;
    logic [2:0] sel;
    logic [7:0] v;
    logic [7:0] mask;
    logic [7:0] res;
    logic [3:0] fo;
    logic       cin;
    logic       cout;
    logic       mem;
    cbsu_rsp_t  p;
    cls  = r.func[7:6];
    sel  = r.func[5:3];
    v    = r.operand;
    mask = 8'b1 << sel;
    cin  = r.flags_in[FLAG_C];
    res  = v;
    fo   = r.flags_in;
    cout = 1'b0;
    mem  = (r.func[2:0] == TARGET_MEM);
    case (cls)
      CLS_SHIFT: begin
        case (sel)
          SH_RLC: begin
            cout = v[7];
            res  = {v[6:0], v[7]};
          end
          SH_RRC: begin
            cout = v[0];
            res  = {v[0], v[7:1]};
          end
          SH_RL: begin
            cout = v[7];
            res  = {v[6:0], cin};
          end
          SH_RR: begin
            cout = v[0];
            res  = {cin, v[7:1]};
          end
          SH_SLA: begin
            cout = v[7];
            res  = {v[6:0], 1'b0};
          end
          SH_SRA: begin
            cout = v[0];
            res  = {v[7], v[7:1]};
          end
          SH_SWAP: begin
            cout = 1'b0;
            res  = {v[3:0], v[7:4]};
          end
          SH_SRL: begin
            cout = v[0];
            res  = {1'b0, v[7:1]};
          end
        endcase
        fo = '0;
        fo[FLAG_Z] = (res == 8'h00);
        fo[FLAG_C] = cout;
      end
      CLS_BIT: begin
        // test only: zero flag from the bit, half carry set, carry kept
        fo = '0;
        fo[FLAG_Z] = ((v & mask) == 8'h00);
        fo[FLAG_H] = 1'b1;
        fo[FLAG_C] = cin;
      end
      CLS_RES: res = v & ~mask;
      CLS_SET: res = v | mask;
    endcase
    p.result       = res;
    p.flags_out    = fo;
    p.write_result = (cls != CLS_BIT);
    p.target_index = r.func[2:0];
    p.uses_memory  = mem;
    if (!mem)
      p.cycle_count = CYC_REG;
    else if (cls == CLS_BIT)
      p.cycle_count = CYC_MEM_BIT;
    else
      p.cycle_count = CYC_MEM;
    return p;
  endfunction

  function automatic cbsu_req_t make_op(logic [1:0] cls, logic [2:0] sel, logic [2:0] tgt,
                                        logic [7:0] operand, logic [3:0] flags);
    cbsu_req_t r;
    r.func     = {cls, sel, tgt};
    r.operand  = operand;
    r.flags_in = flags;
    return r;
  endfunction

  // operands leaning toward zero, all ones and single bits so the zero flag fires often
  function automatic cbsu_req_t random_op();
    cbsu_req_t r;
    r.func     = 8'($urandom_range(0, 255));
    r.flags_in = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 7))
      0:       r.operand = 8'h00;
      1:       r.operand = 8'hFF;
      2:       r.operand = 8'b1 << $urandom_range(0, 7);
      3:       r.operand = ~(8'b1 << $urandom_range(0, 7));
      default: r.operand = 8'($urandom_range(0, 255));
    endcase
    return r;
  endfunction

  // sender: optional idle gap, then hold valid with a steady payload until accepted
  task automatic send_request(input cbsu_req_t r);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    n_issued++;
  endtask

  // stop offering and wait until every issued request has its response back
  task automatic drain_responses();
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (n_retired != n_issued);
  endtask

  // receiver: optional random stall before each response, or a long hold when a test asks
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = rx_idle ? $urandom_range(0, 11) : 0;
      if (rx_hold_cycles > 0) begin
        gap = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
      while (!rsp_valid) @(posedge clk);
    end
  end

  // checker: predict on every accepted request, compare every accepted response
  always @(posedge clk) begin
    cbsu_rsp_t want;
    if (!rst) begin
      if (req_valid && req_ready)
        predicted_rsp_q.push_back(cb_execute(req));
      if (rsp_valid && rsp_ready) begin
        n_retired++;
        if (predicted_rsp_q.size() == 0) begin
          n_errors++;
          $display("%0t: response with no request outstanding, res=%02h", $time, rsp.result);
        end else begin
          want = predicted_rsp_q.pop_front();
          if (rsp.result !== want.result || rsp.flags_out !== want.flags_out ||
              rsp.write_result !== want.write_result ||
              rsp.target_index !== want.target_index ||
              rsp.uses_memory !== want.uses_memory || rsp.cycle_count !== want.cycle_count)
          begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display({"%0t: mismatch exp res=%02h fl=%h wr=%b tgt=%0d mem=%b cyc=%0d",
                        " | got res=%02h fl=%h wr=%b tgt=%0d mem=%b cyc=%0d"},
                       $time, want.result, want.flags_out, want.write_result,
                       want.target_index, want.uses_memory, want.cycle_count,
                       rsp.result, rsp.flags_out, rsp.write_result,
                       rsp.target_index, rsp.uses_memory, rsp.cycle_count);
          end
        end
      end
    end
  end

  // every class, every shift kind, carry in and out, zero results, memory cycle counts
  task automatic test_directed();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_request(make_op(CLS_SHIFT, SH_RLC, REG_B, 8'h80, FL_NONE));
    send_request(make_op(CLS_SHIFT, SH_RRC, REG_C, 8'h01, FL_ALL));
    send_request(make_op(CLS_SHIFT, SH_RL, REG_D, 8'h80, FL_C));     // carry in lands in bit 0
    send_request(make_op(CLS_SHIFT, SH_RL, REG_E, 8'h80, FL_NONE));  // zero result with carry out
    send_request(make_op(CLS_SHIFT, SH_RR, REG_H, 8'h01, FL_C));     // carry in lands in bit 7
    send_request(make_op(CLS_SHIFT, SH_RR, REG_L, 8'h00, FL_ALL));
    send_request(make_op(CLS_SHIFT, SH_SLA, REG_L, 8'hFF, FL_NONE));
    send_request(make_op(CLS_SHIFT, SH_SRA, TARGET_MEM, 8'h81, FL_ALL));
    send_request(make_op(CLS_SHIFT, SH_SWAP, REG_A, 8'hF0, FL_ALL)); // swap clears carry
    send_request(make_op(CLS_SHIFT, SH_SWAP, REG_B, 8'h00, FL_NONE));
    send_request(make_op(CLS_SHIFT, SH_SRL, REG_A, 8'h01, FL_NONE));
    send_request(make_op(CLS_BIT, 3'd0, REG_B, 8'h00, FL_C));        // tested bit clear, carry kept
    send_request(make_op(CLS_BIT, 3'd7, TARGET_MEM, 8'hFF, FL_NONE));
    send_request(make_op(CLS_BIT, 3'd3, REG_A, 8'h08, FL_ALL));
    send_request(make_op(CLS_BIT, 3'd5, REG_C, 8'hDF, FL_ALL));
    send_request(make_op(CLS_RES, 3'd0, REG_B, 8'hFF, FL_ALL));      // flags pass through
    send_request(make_op(CLS_RES, 3'd7, TARGET_MEM, 8'h80, FL_NONE));
    send_request(make_op(CLS_SET, 3'd7, REG_A, 8'h00, 4'hA));
    send_request(make_op(CLS_SET, 3'd0, TARGET_MEM, 8'hFF, 4'h5));
    send_request(make_op(CLS_SHIFT, SH_RLC, REG_B, 8'h00, FL_NONE)); // all-zero request
    send_request(make_op(CLS_SET, 3'd7, REG_A, 8'hFF, FL_ALL));      // all-ones request
    drain_responses();
  endtask

  // bulk random requests with both sides idling at random
  task automatic test_random_mix();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (880) send_request(random_op());
    drain_responses();
  endtask

  // back to back requests, no idling anywhere
  task automatic test_streaming();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (60) send_request(random_op());
    drain_responses();
  endtask

  // receiver holds off for a long stretch so the unit fills and stalls its input
  task automatic test_backpressure();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 150;
    repeat (50) send_request(random_op());
    drain_responses();
  endtask

  // sender pauses mid-stream until everything is back, then resumes
  task automatic test_drain_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (20) send_request(random_op());
    drain_responses();
    repeat (20) send_request(random_op());
    drain_responses();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mix();
    test_streaming();
    test_backpressure();
    test_drain_pause();
    // allow time for any stray response
    repeat (10) @(posedge clk);
    if (predicted_rsp_q.size() != 0) begin
      n_errors++;
      $display("%0d predicted responses never arrived", predicted_rsp_q.size());
    end
    if (n_errors == 0 && n_mismatch == 0)
      $display("cb_prefix_bit_shift_unit_top_test: PASS");
    else
      $display("cb_prefix_bit_shift_unit_top_test: FAIL");
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("cb_prefix_bit_shift_unit_top_test: FAIL");
    $finish;
  end

endmodule

[cb_prefix_bit_shift_unit_top.f]
hw/rtl/cbsu_pkg.sv
hw/rtl/cbsu_exec.sv
hw/rtl/cb_prefix_bit_shift_unit_top.sv
tb/sv/cb_prefix_bit_shift_unit_top_test.sv
